>>> src/lfc_pkg.sv
// Package for the LRU frame cache: request/response structs, state encoding,
// field widths and the default sizes. No dependencies.
`default_nettype none

package lfc_pkg;

    localparam int KEY_W          = 16;
    localparam int DATA_OUT_W     = 64;
    localparam int STAMP_W        = 32;
    localparam int CAP_W          = 7;
    localparam int ENTRIES_DEF    = 64;
    localparam int DATA_WIDTH_DEF = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_SLOT = 1'b1;

    typedef struct packed {
        logic                  kind;
        logic [KEY_W-1:0]      frame_number;
        logic [DATA_OUT_W-1:0] write_data;
    } lfc_req_t;

    typedef struct packed {
        logic                  hit;
        logic                  status;
        logic [DATA_OUT_W-1:0] read_data;
    } lfc_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } lfc_state_t;

endpackage

`default_nettype wire

>>> src/lru_frame_cache.sv
// LRU frame cache top level: sequencer, entry memories and the shared scan unit.
// Depends on lfc_pkg.
`default_nettype none
//
//  channel   signals                       direction  handshake
//  -------   ----------------------------  ---------  ----------------------------------
//  request   start, busy, req              in         taken when start && !busy
//  response  done, rsp                     out        one-cycle strobe, cannot be stalled
//  config    cfg_valid, cfg_ready, cfg_data in        written when cfg_valid && cfg_ready
//
//  On acceptance the scan reads key, payload and stamp at one address per
//  cycle over the filled entries; the registered read data is compared, and
//  the decide/write step and the output register follow. A hit on a get or
//  a put stops the scan early.
//  Reset empties the cache (fill count zero) at once; capacity returns to 64.
//  No stall on the response side: busy drops as done rises, so a new request
//  may start in that cycle.

module lru_frame_cache #(
    parameter int ENTRIES    = lfc_pkg::ENTRIES_DEF,
    parameter int DATA_WIDTH = lfc_pkg::DATA_WIDTH_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire lfc_pkg::lfc_req_t       req,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire [lfc_pkg::CAP_W-1:0]     cfg_data,
    output logic                         done,
    output lfc_pkg::lfc_rsp_t            rsp
);

    import lfc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Entry memories, no reset: only entries below the fill count are compared.
    logic [KEY_W-1:0]      key_mem   [ENTRIES];
    logic [DATA_WIDTH-1:0] data_mem  [ENTRIES];
    logic [STAMP_W-1:0]    stamp_mem [ENTRIES];

    logic [KEY_W-1:0]      rd_key_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [STAMP_W-1:0]    rd_stamp_reg;
    logic [IDX_W-1:0]      rd_addr;

    // Control state
    lfc_state_t            state_reg, state_next;
    logic [CNT_W-1:0]      issue_idx_reg, issue_idx_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                  hit_reg, hit_next;
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    logic [DATA_WIDTH-1:0] hit_data_reg, hit_data_next;
    logic                  best_valid_reg, best_valid_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic [STAMP_W-1:0]    best_stamp_reg, best_stamp_next;
    logic [CNT_W-1:0]      fill_reg, fill_next;
    logic [STAMP_W-1:0]    stamp_ctr_reg, stamp_ctr_next;
    logic [CAP_W-1:0]      cap_reg, cap_next;
    logic                  done_reg, done_next;
    lfc_rsp_t              rsp_reg, rsp_next;
    lfc_req_t              req_reg;

    // Memory write controls from the decide step
    logic                  stamp_we;
    logic                  entry_we;
    logic [IDX_W-1:0]      wr_idx;

    // Full test against the effective capacity (saturated at ENTRIES)
    logic [CMP_W-1:0]      fill_ext, cap_ext, eff_cap;
    logic                  cache_full;
    logic                  is_put;
    logic                  issue;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign done      = done_reg;
    assign rsp       = rsp_reg;

    assign rd_addr  = issue_idx_reg[IDX_W-1:0];
    assign is_put   = (req_reg.kind == KIND_PUT);
    assign issue    = (issue_idx_reg < fill_reg);

    assign fill_ext   = CMP_W'(fill_reg);
    assign cap_ext    = CMP_W'(cap_reg);
    assign eff_cap    = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
    assign cache_full = (fill_ext >= eff_cap);

    // Hold the request for the whole scan
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= req;
        end
    end

    // Memories: one write port, one registered read at the scan address
    always_ff @(posedge clk)
    begin
        if (stamp_we)
        begin
            stamp_mem[wr_idx] <= stamp_ctr_reg;
        end
        if (entry_we)
        begin
            key_mem[wr_idx]  <= req_reg.frame_number;
            data_mem[wr_idx] <= req_reg.write_data[DATA_WIDTH-1:0];
        end
        rd_key_reg   <= key_mem[rd_addr];
        rd_data_reg  <= data_mem[rd_addr];
        rd_stamp_reg <= stamp_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            issue_idx_reg  <= '0;
            cmp_valid_reg  <= 1'b0;
            cmp_idx_reg    <= '0;
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            best_valid_reg <= 1'b0;
            best_idx_reg   <= '0;
            fill_reg       <= '0;
            stamp_ctr_reg  <= '0;
            cap_reg        <= CAP_RESET;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_idx_reg  <= issue_idx_next;
            cmp_valid_reg  <= cmp_valid_next;
            cmp_idx_reg    <= cmp_idx_next;
            hit_reg        <= hit_next;
            hit_idx_reg    <= hit_idx_next;
            best_valid_reg <= best_valid_next;
            best_idx_reg   <= best_idx_next;
            fill_reg       <= fill_next;
            stamp_ctr_reg  <= stamp_ctr_next;
            cap_reg        <= cap_next;
            done_reg       <= done_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        hit_data_reg   <= hit_data_next;
        best_stamp_reg <= best_stamp_next;
        rsp_reg        <= rsp_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        issue_idx_next  = issue_idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_data_next   = hit_data_reg;
        best_valid_next = best_valid_reg;
        best_idx_next   = best_idx_reg;
        best_stamp_next = best_stamp_reg;
        fill_next       = fill_reg;
        stamp_ctr_next  = stamp_ctr_reg;
        cap_next        = cap_reg;
        done_next       = 1'b0;
        rsp_next        = rsp_reg;
        stamp_we        = 1'b0;
        entry_we        = 1'b0;
        wr_idx          = hit_idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    cap_next = cfg_data;
                end
                if (start)
                begin
                    issue_idx_next  = '0;
                    cmp_valid_next  = 1'b0;
                    hit_next        = 1'b0;
                    best_valid_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Issue stage: advance the read address over filled entries
                cmp_valid_next = issue;
                cmp_idx_next   = rd_addr;
                if (issue)
                begin
                    issue_idx_next = CNT_W'(issue_idx_reg + 1'b1);
                end

                // Compare stage: key match stops the scan, else track oldest
                if (cmp_valid_reg)
                begin
                    if (rd_key_reg == req_reg.frame_number)
                    begin
                        hit_next       = 1'b1;
                        hit_idx_next   = cmp_idx_reg;
                        hit_data_next  = rd_data_reg;
                        cmp_valid_next = 1'b0;
                        state_next     = ST_DECIDE;
                    end
                    else if (!best_valid_reg || (best_stamp_reg > rd_stamp_reg))
                    begin
                        best_valid_next = 1'b1;
                        best_idx_next   = cmp_idx_reg;
                        best_stamp_next = rd_stamp_reg;
                    end
                end
                else if (!issue)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                rsp_next.hit       = hit_reg;
                rsp_next.status    = STATUS_OK;
                rsp_next.read_data = '0;
                if (!is_put)
                begin
                    if (hit_reg)
                    begin
                        stamp_we           = 1'b1;
                        stamp_ctr_next     = stamp_ctr_reg + 1'b1;
                        rsp_next.read_data = DATA_OUT_W'(hit_data_reg);
                    end
                end
                else if (hit_reg)
                begin
                    stamp_we       = 1'b1;
                    entry_we       = 1'b1;
                    stamp_ctr_next = stamp_ctr_reg + 1'b1;
                end
                else if (!cache_full)
                begin
                    // Fill the next free slot
                    wr_idx         = fill_reg[IDX_W-1:0];
                    stamp_we       = 1'b1;
                    entry_we       = 1'b1;
                    fill_next      = CNT_W'(fill_reg + 1'b1);
                    stamp_ctr_next = stamp_ctr_reg + 1'b1;
                end
                else if (best_valid_reg)
                begin
                    // Replace the least recently used entry
                    wr_idx         = best_idx_reg;
                    stamp_we       = 1'b1;
                    entry_we       = 1'b1;
                    stamp_ctr_next = stamp_ctr_reg + 1'b1;
                end
                else
                begin
                    rsp_next.status = STATUS_NO_SLOT;
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/lfc_checker.sv
// Port-level checker for the LRU frame cache, bound to the top level.
// Depends on lfc_pkg and lru_frame_cache.
`default_nettype none

module lfc_checker (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    start,
    input  wire                    busy,
    input  wire                    done,
    input  wire lfc_pkg::lfc_rsp_t rsp
);

    import lfc_pkg::*;

    // A response comes out only once the sequencer is back to idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("done while busy");

    // An accepted request always occupies the block in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // One strobe per request: never two in a row
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("back-to-back done strobes");

    // A failed put is never a hit and returns zero data
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status == STATUS_NO_SLOT)) |-> (!rsp.hit && (rsp.read_data == '0)))
        else $error("no-slot status with hit or data");

    // Misses return zero data
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.hit) |-> (rsp.read_data == '0))
        else $error("miss with nonzero read data");

endmodule

bind lru_frame_cache lfc_checker u_lfc_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

`default_nettype wire
